@@ design/assert_macros.svh @@
// Assertion macros used by the dequantiser design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Implication checked at every clock edge outside reset.
`define MCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked with the non-overlapping operator |=>.
`define MCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MCD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/mcd_pkg.sv @@
// Shared codes, constants and tables of the coefficient dequantiser.
package mcd_pkg;

  localparam logic [1:0] MODE_DEQUANT      = 2'd0;
  localparam logic [1:0] MODE_LOAD_INTRA   = 2'd1;
  localparam logic [1:0] MODE_LOAD_NONINTRA = 2'd2;

  localparam logic REG_DC_PRECISION    = 1'b0;
  localparam logic REG_NONLINEAR_SCALE = 1'b1;

  localparam int unsigned MatDepth = 64;
  localparam int unsigned AddrW    = $clog2(MatDepth);

  localparam logic signed [24:0] ValueMax = 25'sd2047;
  localparam logic signed [24:0] ValueMin = -25'sd2048;

  // MPEG-2 non-linear quantiser scale.
  function automatic logic [6:0] nonlinear_q(input logic [4:0] code);
    logic [6:0] q;
    unique case (code)
      5'd0:  q = 7'd0;
      5'd1:  q = 7'd1;
      5'd2:  q = 7'd2;
      5'd3:  q = 7'd3;
      5'd4:  q = 7'd4;
      5'd5:  q = 7'd5;
      5'd6:  q = 7'd6;
      5'd7:  q = 7'd7;
      5'd8:  q = 7'd8;
      5'd9:  q = 7'd10;
      5'd10: q = 7'd12;
      5'd11: q = 7'd14;
      5'd12: q = 7'd16;
      5'd13: q = 7'd18;
      5'd14: q = 7'd20;
      5'd15: q = 7'd22;
      5'd16: q = 7'd24;
      5'd17: q = 7'd28;
      5'd18: q = 7'd32;
      5'd19: q = 7'd36;
      5'd20: q = 7'd40;
      5'd21: q = 7'd44;
      5'd22: q = 7'd48;
      5'd23: q = 7'd52;
      5'd24: q = 7'd56;
      5'd25: q = 7'd64;
      5'd26: q = 7'd72;
      5'd27: q = 7'd80;
      5'd28: q = 7'd88;
      5'd29: q = 7'd96;
      5'd30: q = 7'd104;
      5'd31: q = 7'd112;
      default: q = 7'd0;
    endcase
    return q;
  endfunction

endpackage

@@ design/mpeg_coefficient_dequantiser.sv @@
// Five-stage pipelined MPEG-2 coefficient dequantiser with weight matrices.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  mode, position, coefficient, intra, scale_code, weight
//   out_     output     out_valid/out_stall position_out, value
//   cfg_     input      cfg_valid/cfg_ready index, wdata (dc_precision, nonlinear_scale)
//
// One item enters per cycle while in_stall is low. A dequantise item shows its result in the
// output register; load items and the unused mode give no result and only occupy a slot.
// The pipeline moves as one: while the output register holds an item that is stalled,
// every stage holds and in_stall is raised, so nothing is lost or repeated.
// Reset clears the valid bits and the configuration registers; the weight matrices
// hold whatever they held until they are loaded.
`include "assert_macros.svh"

module mpeg_coefficient_dequantiser
  import mcd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  // Input items.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_mode,
  input  logic [5:0]               in_position,
  input  logic signed [11:0]       in_coefficient,
  input  logic                     in_intra,
  input  logic [4:0]               in_scale_code,
  input  logic [7:0]               in_weight,
  // Result items.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [5:0]               out_position_out,
  output logic signed [11:0]       out_value,
  // Configuration writes.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [1:0]               cfg_wdata
);

  // Configuration registers.
  logic [1:0] dc_precision_r;
  logic       nonlinear_scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_precision_r    <= 2'd0;
      nonlinear_scale_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DC_PRECISION:    dc_precision_r    <= cfg_wdata;
        REG_NONLINEAR_SCALE: nonlinear_scale_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless the output register holds a stalled item.
  logic adv;
  logic in_accept;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign in_accept = in_valid && adv;

  // Stage 1: weight matrix read, quantiser scale lookup.
  // The matrices are written at the edge that accepts a load item, so a dequantise
  // item that follows in the next cycle already reads the new weight.
  logic [7:0] intra_mem [MatDepth];
  logic [7:0] nonintra_mem [MatDepth];

  logic              v1_r;
  logic [7:0]        w1_r;
  logic [6:0]        q1_r;
  logic signed [11:0] c1_r;
  logic              intra1_r;
  logic              dc1_r;
  logic [5:0]        pos1_r;
  logic [6:0]        q_nxt;

  assign q_nxt = nonlinear_scale_r ? nonlinear_q(in_scale_code) : {1'b0, in_scale_code, 1'b0};

  always_ff @(posedge clk) begin
    if (in_accept && in_mode == MODE_LOAD_INTRA) begin
      intra_mem[in_position[AddrW-1:0]] <= in_weight;
    end
    if (in_accept && in_mode == MODE_LOAD_NONINTRA) begin
      nonintra_mem[in_position[AddrW-1:0]] <= in_weight;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w1_r     <= in_intra ? intra_mem[in_position[AddrW-1:0]]
                           : nonintra_mem[in_position[AddrW-1:0]];
      q1_r     <= q_nxt;
      c1_r     <= in_coefficient;
      intra1_r <= in_intra;
      dc1_r    <= in_intra && (in_position == 6'd0);
      pos1_r   <= in_position;
    end
  end

  // Stage 2: weight times scale, and the scaled level 2c (+ sign for non-intra).
  logic              v2_r;
  logic [14:0]       m2_r;
  logic signed [13:0] k2_r;
  logic signed [11:0] c2_r;
  logic              dc2_r;
  logic [5:0]        pos2_r;
  logic signed [13:0] k_nxt;
  logic signed [13:0] sgn;

  always_comb begin
    if (intra1_r || c1_r == 12'sd0) begin
      sgn = 14'sd0;
    end else if (c1_r[11]) begin
      sgn = -14'sd1;
    end else begin
      sgn = 14'sd1;
    end
    k_nxt = $signed({c1_r[11], c1_r, 1'b0}) + sgn;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_r   <= {7'd0, w1_r} * {8'd0, q1_r};
      k2_r   <= k_nxt;
      c2_r   <= c1_r;
      dc2_r  <= dc1_r;
      pos2_r <= pos1_r;
    end
  end

  // Stage 3: full product.
  logic              v3_r;
  logic signed [29:0] p3_r;
  logic signed [11:0] c3_r;
  logic              dc3_r;
  logic [5:0]        pos3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_r   <= k2_r * $signed({1'b0, m2_r});
      c3_r   <= c2_r;
      dc3_r  <= dc2_r;
      pos3_r <= pos2_r;
    end
  end

  // Stage 4: divide by 32 toward zero, make an even nonzero result odd toward zero,
  // or take the intra DC path, which only scales by a power of two.
  logic              v4_r;
  logic signed [24:0] r4_r;
  logic              dc4_r;
  logic [5:0]        pos4_r;
  logic signed [29:0] p_bias;
  logic signed [24:0] r_div;
  logic signed [24:0] r_odd;
  logic signed [24:0] r_dc;
  logic [1:0]        dc_shift;

  always_comb begin
    p_bias   = p3_r + (p3_r[29] ? 30'sd31 : 30'sd0);
    r_div    = p_bias[29:5];
    if (r_div != 25'sd0 && !r_div[0]) begin
      r_odd = r_div[24] ? r_div + 25'sd1 : r_div - 25'sd1;
    end else begin
      r_odd = r_div;
    end
    dc_shift = 2'd3 - dc_precision_r;
    r_dc     = $signed({{13{c3_r[11]}}, c3_r}) <<< dc_shift;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r4_r   <= dc3_r ? r_dc : r_odd;
      dc4_r  <= dc3_r;
      pos4_r <= pos3_r;
    end
  end

  // Stage 5: saturate into the output register.
  logic              out_valid_r;
  logic signed [11:0] out_value_r;
  logic [5:0]        out_pos_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (r4_r > ValueMax) begin
        out_value_r <= 12'sd2047;
      end else if (r4_r < ValueMin) begin
        out_value_r <= -12'sd2048;
      end else begin
        out_value_r <= r4_r[11:0];
      end
      out_pos_r <= pos4_r;
    end
  end

  // Valid bits: only dequantise items carry a valid bit down the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_accept && (in_mode == MODE_DEQUANT);
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_value        = out_value_r;
  assign out_position_out = out_pos_r;

  // A load or unused-mode item never starts a result.
  `MCD_ASSERT_NEXT(a_load_no_result, clk, rst_n,
    in_accept && in_mode != MODE_DEQUANT, !v1_r)
  // Every non-DC result leaving the rounding stage is zero or odd.
  `MCD_ASSERT_IMPL(a_odd_result, clk, rst_n,
    v4_r && !dc4_r && r4_r != 25'sd0, r4_r[0])
  // While the pipeline is held, no stage gains or drops an item.
  `MCD_ASSERT_NEXT(a_hold_valids, clk, rst_n,
    !adv, $stable({v1_r, v2_r, v3_r, v4_r, out_valid_r}))

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the MPEG-2 coefficient dequantiser.
`timescale 1ns / 1ps

module tb_top;
  import mcd_pkg::*;

  // Mode 3 has no meaning in the block; items carrying it must be dropped silently.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // The watchdog limit is far above the slowest legal run. Items go through with both
  // sides idling, and each phase ends with a short drain.
  localparam int CycleLimit    = 200000;
  // The pipeline is five stages deep. Loads give no result, so a few more cycles cover them.
  localparam int DrainCycles   = 10;
  localparam int Phases        = 6;
  localparam int ItemsPerPhase = 185;

  typedef struct packed {
    logic [1:0]        mode;
    logic [5:0]        position;
    logic signed [11:0] coefficient;
    logic              intra;
    logic [4:0]        scale_code;
    logic [7:0]        weight;
  } coef_item_t;

  typedef struct packed {
    logic [5:0]        position;
    logic signed [11:0] value;
  } coef_result_t;

  // One row of the directed table. Where typed is set, value is the result written by hand.
  typedef struct packed {
    coef_item_t        item;
    logic              typed;
    logic signed [11:0] value;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_mode = MODE_DEQUANT;
  logic [5:0]         in_position = '0;
  logic signed [11:0] in_coefficient = '0;
  logic               in_intra = 1'b0;
  logic [4:0]         in_scale_code = '0;
  logic [7:0]         in_weight = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [5:0]         out_position_out;
  logic signed [11:0] out_value;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = REG_DC_PRECISION;
  logic [1:0]         cfg_wdata = '0;

  // Our own copy of the block's configuration and weight matrices. The set flags record
  // which entries were loaded, so that the stimulus never reads one that was not.
  logic [1:0] cur_dc_precision = '0;
  logic       cur_nonlinear = 1'b0;
  logic [7:0] intra_w [64];
  logic [7:0] nonintra_w [64];
  bit         intra_w_set [64];
  bit         nonintra_w_set [64];

  // Results that were worked out and not yet seen on the output, oldest first.
  coef_result_t pending_coefs[$];
  table_row_t   directed_rows[$];

  // While calm is high, neither side idles. This gives a long stretch at full rate.
  logic calm = 1'b0;

  int cycle_count = 0;
  int n_accepted = 0;
  int n_dequant = 0;
  int n_saturated = 0;
  int n_loads = 0;
  int n_ignored = 0;
  int n_results = 0;
  int n_settings = 1;
  int n_errors = 0;

  mpeg_coefficient_dequantiser i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_position      (in_position),
    .in_coefficient   (in_coefficient),
    .in_intra         (in_intra),
    .in_scale_code    (in_scale_code),
    .in_weight        (in_weight),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position_out (out_position_out),
    .out_value        (out_value),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Dequantises one level with the current configuration and weights.
  // The arithmetic is done on 64-bit signed values, so nothing wraps before the clamp.
  // Signed division truncates toward zero.
  function automatic logic signed [11:0] dequant_coefficient(input logic [5:0] pos,
      input logic signed [11:0] level, input logic intra, input logic [4:0] code);
    longint c, q, w, r, s, code_l;
    c = level;
    code_l = code;
    if (intra && pos == 0) begin
      // Intra DC is scaled only by the DC precision. The quantiser scale plays no part.
      r = c * (8 >> cur_dc_precision);
    end else begin
      if (!cur_nonlinear) begin
        q = 2 * code_l;
      end else if (code_l <= 8) begin
        // The non-linear table has four segments: slopes 1, 2, 4 and 8.
        q = code_l;
      end else if (code_l <= 16) begin
        q = 2 * code_l - 8;
      end else if (code_l <= 24) begin
        q = 4 * code_l - 40;
      end else begin
        q = 8 * code_l - 136;
      end
      if (intra) begin
        w = intra_w[pos];
        r = (c * w * q * 2) / 32;
      end else begin
        s = (c > 0) ? 1 : ((c < 0) ? -1 : 0);
        w = nonintra_w[pos];
        r = ((2 * c + s) * w * q) / 32;
      end
      // Mismatch control: a nonzero even result steps one toward zero and so becomes odd.
      if (r != 0 && r[0] == 1'b0) begin
        r += (r > 0) ? -1 : 1;
      end
    end
    if (r > 2047) begin
      r = 2047;
    end
    if (r < -2048) begin
      r = -2048;
    end
    return r[11:0];
  endfunction

  task automatic add_row(input logic [1:0] mode, input int pos, input int level,
      input int intra, input int code, input int weight, input int typed, input int value);
    table_row_t r;
    r.item.mode        = mode;
    r.item.position    = pos[5:0];
    r.item.coefficient = level[11:0];
    r.item.intra       = intra[0];
    r.item.scale_code  = code[4:0];
    r.item.weight      = weight[7:0];
    r.typed            = typed[0];
    r.value            = value[11:0];
    directed_rows.push_back(r);
  endtask

  // Applies an accepted item to our copy of the block. For a dequantise item, the result it
  // must produce is queued.
  task automatic absorb(input coef_item_t it, input logic typed,
      input logic signed [11:0] typed_value);
    coef_result_t e;
    n_accepted++;
    calm <= (n_accepted >= 400 && n_accepted < 650);
    case (it.mode)
      MODE_LOAD_INTRA: begin
        intra_w[it.position] = it.weight;
        intra_w_set[it.position] = 1'b1;
        n_loads++;
      end
      MODE_LOAD_NONINTRA: begin
        nonintra_w[it.position] = it.weight;
        nonintra_w_set[it.position] = 1'b1;
        n_loads++;
      end
      MODE_DEQUANT: begin
        e.position = it.position;
        e.value = typed ? typed_value :
                  dequant_coefficient(it.position, it.coefficient, it.intra, it.scale_code);
        if ($signed(e.value) == 2047 || $signed(e.value) == -2048) begin
          n_saturated++;
        end
        pending_coefs.push_back(e);
        n_dequant++;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endtask

  // Presents one item after an optional random gap. The item is held until the block
  // takes it. Acceptance is judged from the values that stood at the clock edge.
  task automatic push_item(input coef_item_t it, input logic typed,
      input logic signed [11:0] typed_value);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= it.mode;
    in_position    <= it.position;
    in_coefficient <= it.coefficient;
    in_intra       <= it.intra;
    in_scale_code  <= it.scale_code;
    in_weight      <= it.weight;
    do @(posedge clk); while (in_stall);
    absorb(it, typed, typed_value);
  endtask

  // Waits for every queued result. Then it waits a few more cycles, because loads still in
  // the pipeline give no result to wait for.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Writes both registers back to back. cfg_valid stays high between the two writes.
  task automatic set_registers(input logic [1:0] dc, input logic nl);
    cfg_valid <= 1'b1;
    cfg_index <= REG_DC_PRECISION;
    cfg_wdata <= dc;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_NONLINEAR_SCALE;
    cfg_wdata <= {1'b0, nl};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_dc_precision = dc;
    cur_nonlinear = nl;
    n_settings++;
  endtask

  // Random item. Most items are dequantise requests, and about a fifth are weight loads. Levels
  // lean toward small values and toward the ends of the range. A request that would read a
  // weight that was never loaded turns into a load of that entry.
  function automatic coef_item_t random_item();
    coef_item_t it;
    int k;
    int lvl;
    k = $urandom_range(0, 99);
    if (k < 10) begin
      it.mode = MODE_LOAD_INTRA;
    end else if (k < 20) begin
      it.mode = MODE_LOAD_NONINTRA;
    end else if (k < 23) begin
      it.mode = MODE_UNUSED;
    end else begin
      it.mode = MODE_DEQUANT;
    end

    k = $urandom_range(0, 99);
    if (k < 15) begin
      it.position = 6'd0;
    end else if (k < 25) begin
      it.position = 6'd63;
    end else begin
      it.position = 6'($urandom_range(0, 63));
    end

    it.intra = 1'($urandom_range(0, 1));

    k = $urandom_range(0, 99);
    if (k < 10) begin
      case ($urandom_range(0, 4))
        0: lvl = 2047;
        1: lvl = -2048;
        2: lvl = 0;
        3: lvl = 1;
        default: lvl = -1;
      endcase
    end else if (k < 40) begin
      lvl = $urandom_range(0, 16) - 8;
    end else begin
      lvl = $urandom_range(0, 4095);
    end
    it.coefficient = lvl[11:0];

    k = $urandom_range(0, 99);
    if (k < 5) begin
      it.scale_code = 5'd0;
    end else if (k < 10) begin
      it.scale_code = 5'd31;
    end else begin
      it.scale_code = 5'($urandom_range(0, 31));
    end

    k = $urandom_range(0, 99);
    if (k < 10) begin
      it.weight = 8'd0;
    end else if (k < 20) begin
      it.weight = 8'd255;
    end else begin
      it.weight = 8'($urandom_range(0, 255));
    end

    if (it.mode == MODE_DEQUANT && !(it.intra && it.position == 0)) begin
      if (it.intra && !intra_w_set[it.position]) begin
        it.mode = MODE_LOAD_INTRA;
      end else if (!it.intra && !nonintra_w_set[it.position]) begin
        it.mode = MODE_LOAD_NONINTRA;
      end
    end
    return it;
  endfunction

  // Compares the result taken at this edge with the oldest one we queued.
  task automatic check_result();
    coef_result_t e;
    n_results++;
    if (pending_coefs.size() == 0) begin
      $error("result at position %0d with no item pending", out_position_out);
      n_errors++;
      return;
    end
    e = pending_coefs.pop_front();
    if (out_position_out !== e.position) begin
      $error("position_out: expected %0d, got %0d", e.position, out_position_out);
      n_errors++;
    end
    if (out_value !== e.value) begin
      $error("value: expected %0d, got %0d", $signed(e.value), $signed(out_value));
      n_errors++;
    end
  endtask

  // The result side. A result is taken at an edge where out_valid is high and out_stall is low.
  // The stall for the next cycle is chosen at random here, except during the calm stretch.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_result();
    end
    out_stall <= (!calm && $urandom_range(0, 99) < 30);
  end

  // Watchdog. A hang or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int taken;
    logic [1:0] dc_sel;
    logic nl_sel;

    // Directed table, one item per row: mode, position, level, intra, scale code, weight,
    // then a flag and a value for results written by hand. Only the weights the table reads
    // are loaded. The first rows run with the configuration left by reset: DC multiplier 8,
    // linear scale.
    add_row(MODE_LOAD_INTRA,    1,     0, 0,  0,  16, 0,     0);
    add_row(MODE_LOAD_INTRA,    63,    0, 0,  0, 255, 0,     0);
    add_row(MODE_LOAD_INTRA,    5,     0, 0,  0,   0, 0,     0);
    add_row(MODE_LOAD_NONINTRA, 1,     0, 0,  0,  16, 0,     0);
    add_row(MODE_LOAD_NONINTRA, 63,    0, 0,  0, 255, 0,     0);
    add_row(MODE_LOAD_NONINTRA, 0,     0, 0,  0,   1, 0,     0);
    // The unused mode must not overwrite entry 1. The rows that read entry 1 later show it.
    add_row(MODE_UNUSED,        1,    -1, 1, 31, 200, 0,     0);
    // Intra DC: saturation at both ends, plain scaling, and a scale code of zero.
    add_row(MODE_DEQUANT,       0,  2047, 1,  1,   0, 1,  2047);
    add_row(MODE_DEQUANT,       0, -2048, 1,  1,   0, 1, -2048);
    add_row(MODE_DEQUANT,       0,   100, 1, 31,   0, 1,   800);
    add_row(MODE_DEQUANT,       0,     0, 1,  7,   0, 1,     0);
    add_row(MODE_DEQUANT,       0,     5, 1,  0,   0, 1,    40);
    // Intra AC: even results made odd, saturation, scale code zero, zero weight.
    add_row(MODE_DEQUANT,       1,     1, 1,  1,   0, 1,     1);
    add_row(MODE_DEQUANT,       1,    -1, 1,  1,   0, 1,    -1);
    add_row(MODE_DEQUANT,       63, 2047, 1, 31,   0, 1,  2047);
    add_row(MODE_DEQUANT,       63,-2048, 1, 31,   0, 1, -2048);
    add_row(MODE_DEQUANT,       63,  500, 1,  0,   0, 1,     0);
    add_row(MODE_DEQUANT,       5,     7, 1, 20,   0, 1,     0);
    // Non-intra: the sign term, a zero level, and saturation.
    add_row(MODE_DEQUANT,       1,     1, 0,  1,   0, 1,     3);
    add_row(MODE_DEQUANT,       1,    -1, 0,  1,   0, 1,    -3);
    add_row(MODE_DEQUANT,       1,     0, 0, 31,   0, 1,     0);
    add_row(MODE_DEQUANT,       63, 2047, 0, 31,   0, 1,  2047);
    add_row(MODE_DEQUANT,       63,-2048, 0, 31,   0, 1, -2048);
    // These need real arithmetic, so the predictor works them out.
    add_row(MODE_DEQUANT,       0,  2047, 0,  1,   0, 0,     0);
    add_row(MODE_DEQUANT,       63,   37, 1, 17,   0, 0,     0);
    add_row(MODE_DEQUANT,       1,    -3, 0,  5,   0, 0,     0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].value);
    end

    // Random phases. Each one starts from an idle block with new register values. The DC
    // precision runs through 0, 3, 2 and 1, and the scale mode alternates.
    for (int p = 0; p < Phases; p++) begin
      wait_idle();
      dc_sel = 2'((p * 3) % 4);
      nl_sel = 1'(p % 2);
      set_registers(dc_sel, nl_sel);
      taken = 0;
      while (taken < ItemsPerPhase) begin
        coef_item_t it;
        it = random_item();
        if (it.mode != MODE_UNUSED) begin
          taken++;
        end
        push_item(it, 1'b0, '0);
      end
    end

    wait_idle();
    $display("Covered %0d dequantise items (%0d saturated), %0d weight loads, %0d ignored",
             n_dequant, n_saturated, n_loads, n_ignored);
    $display("under %0d register settings; %0d results compared, %0d errors",
             n_settings, n_results, n_errors);
    if (n_errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/mcd_pkg.sv
design/mpeg_coefficient_dequantiser.sv
tb/sv/tb_top.sv
